// ----- src/rcm_pkg.sv -----
// Shared types, register indexes, curve tables and constants for the stick channel mixer.
// Depends on nothing; every other file of the block imports it.
package rcm_pkg;

	localparam int SAMPLE_W     = 10;
	localparam int CURVE_POINTS = 15;

	// Configuration register indexes on the write port.
	typedef enum logic [2:0] {
		REG_CAL_LOW     = 3'd0,
		REG_CAL_CENTER  = 3'd1,
		REG_CAL_HIGH    = 3'd2,
		REG_EXPO_AMOUNT = 3'd3,
		REG_RATE        = 3'd4,
		REG_SUB_TRIM    = 3'd5,
		REG_END_POINTS  = 3'd6,
		REG_MODE_BITS   = 3'd7
	} reg_idx_t;

	// Complete configuration as seen by the datapath.
	typedef struct packed {
		logic [SAMPLE_W-1:0] cal_low;
		logic [SAMPLE_W-1:0] cal_center;
		logic [SAMPLE_W-1:0] cal_high;
		logic signed [7:0]   expo_amount;
		logic [7:0]          rate_percent;
		logic signed [7:0]   sub_trim;
		logic [15:0]         end_points;
		logic [1:0]          mode_bits;
	} cfg_t;

	// One stage of the normalising divider.
	typedef struct packed {
		logic                neg;
		logic                at_low;
		logic                at_high;
		logic                span_zero;
		logic [1:0]          shifts;
		logic [SAMPLE_W-1:0] span;
		logic [SAMPLE_W-1:0] rem;
		logic [7:0]          quo;
	} div_t;

	localparam int DIV_STEPS = 8;

	localparam logic [8:0]  MAG_FULL  = 9'd256;
	localparam logic [7:0]  OUT_MAX   = 8'd255;
	localparam logic [6:0]  PCT_FULL  = 7'd100;

	// Division by 100 as multiply by reciprocal, exact below 199728.
	localparam logic [17:0] DIV100_MUL = 18'd167773;
	localparam int          DIV100_SH  = 24;
	// Division by 140 as multiply by reciprocal, exact below 479000.
	localparam logic [17:0] DIV140_MUL = 18'd239675;
	localparam int          DIV140_SH  = 25;

	localparam logic [7:0] CURVE_CUBIC [CURVE_POINTS] = '{
		8'd0, 8'd1, 8'd2, 8'd4, 8'd8, 8'd14, 8'd21, 8'd32,
		8'd46, 8'd63, 8'd83, 8'd108, 8'd137, 8'd171, 8'd210
	};
	localparam logic [7:0] CURVE_ROOT [CURVE_POINTS] = '{
		8'd101, 8'd128, 8'd147, 8'd161, 8'd174, 8'd185, 8'd194, 8'd203,
		8'd211, 8'd219, 8'd226, 8'd232, 8'd239, 8'd245, 8'd251
	};

	// Curve point: zero below the table, full scale above it.
	function automatic logic [8:0] curve_at(input logic cubic, input logic [4:0] idx);
		logic [3:0] pos;
		pos = 4'(idx - 5'd1);
		if (idx == 5'd0) begin
			return 9'd0;
		end else if (idx > 5'(CURVE_POINTS)) begin
			return MAG_FULL;
		end else if (cubic) begin
			return {1'b0, CURVE_CUBIC[pos]};
		end else begin
			return {1'b0, CURVE_ROOT[pos]};
		end
	endfunction

endpackage

// ----- src/rc_stick_channel_mixer.sv -----
// Top level of the stick channel mixer: configuration registers, flow control and the pipeline.
// Depends on rcm_pkg, rcm_norm, rcm_shape and rcm_endpt.
//
//   Channel   | Signals                          | Direction
//   ----------+----------------------------------+-----------------------------
//   input     | in_valid, in_stall, stick_sample | one sample per beat in
//   output    | out_valid, out_stall, channel_value | one channel value per beat out
//   config    | wr_en, wr_index, wr_data         | register writes, no read-back
//
// One beat is accepted per cycle while in_stall is low; the depth of the pipeline is
// set by the eight-stage normalising divider and the reciprocal multipliers.
// Reset clears the valid bits and loads the register defaults.
// While a result waits with out_stall high, the whole pipeline holds and in_stall is raised.
module rc_stick_channel_mixer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [rcm_pkg::SAMPLE_W-1:0] stick_sample,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   channel_value,
	input  logic                         wr_en,
	input  logic [2:0]                   wr_index,
	input  logic [15:0]                  wr_data
);
	import rcm_pkg::*;

	cfg_t       cfg_q;
	logic       en;
	logic       n_valid, n_neg;
	logic [8:0] n_mag;
	logic       s_valid, s_neg;
	logic [9:0] s_mag;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cal_low      <= 10'd0;
			cfg_q.cal_center   <= 10'd512;
			cfg_q.cal_high     <= 10'd1023;
			cfg_q.expo_amount  <= 8'sd0;
			cfg_q.rate_percent <= 8'd100;
			cfg_q.sub_trim     <= 8'sd0;
			cfg_q.end_points   <= 16'd35980;
			cfg_q.mode_bits    <= 2'd0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_CAL_LOW:     cfg_q.cal_low      <= wr_data[9:0];
				REG_CAL_CENTER:  cfg_q.cal_center   <= wr_data[9:0];
				REG_CAL_HIGH:    cfg_q.cal_high     <= wr_data[9:0];
				REG_EXPO_AMOUNT: cfg_q.expo_amount  <= wr_data[7:0];
				REG_RATE:        cfg_q.rate_percent <= wr_data[7:0];
				REG_SUB_TRIM:    cfg_q.sub_trim     <= wr_data[7:0];
				REG_END_POINTS:  cfg_q.end_points   <= wr_data;
				REG_MODE_BITS:   cfg_q.mode_bits    <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	// The pipeline advances unless a finished beat is held at the output.
	assign in_stall = out_valid && out_stall;
	assign en       = !in_stall;

	rcm_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.sample    (stick_sample),
		.cfg       (cfg_q),
		.out_valid (n_valid),
		.out_neg   (n_neg),
		.out_mag   (n_mag)
	);

	rcm_shape u_shape (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (n_valid),
		.in_neg    (n_neg),
		.in_mag    (n_mag),
		.cfg       (cfg_q),
		.out_valid (s_valid),
		.out_neg   (s_neg),
		.out_mag   (s_mag)
	);

	rcm_endpt u_endpt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_valid),
		.in_neg    (s_neg),
		.in_mag    (s_mag),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_value (channel_value)
	);

	// The normalised magnitude never exceeds full scale.
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		n_valid |-> n_mag <= MAG_FULL)
		else $error("normalised magnitude above full scale");

	// With dual rate at most 100 percent, shaping never grows the value past full scale.
	a_shape_range: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && cfg_q.rate_percent <= 8'd100 |-> s_mag <= 10'(MAG_FULL))
		else $error("shaped magnitude above full scale");

	// A stalled pipeline keeps its internal valid bits.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(n_valid) && $stable(s_valid))
		else $error("pipeline moved while stalled");

endmodule

// ----- src/rcm_norm.sv -----
// Normalisation of the raw sample against the calibration, with an eight-stage divider.
// Depends on rcm_pkg.
module rcm_norm (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [rcm_pkg::SAMPLE_W-1:0] sample,
	input  rcm_pkg::cfg_t                cfg,
	output logic                         out_valid,
	output logic                         out_neg,
	output logic [8:0]                   out_mag
);
	import rcm_pkg::*;

	logic                above;
	logic [SAMPLE_W-1:0] mag_raw;
	div_t                front;
	div_t                dstage_s [DIV_STEPS+1];
	logic                dvalid_s [DIV_STEPS+1];
	logic [SAMPLE_W-1:0] q_shift;

	// Side, distance and span, with the magnitude pre-shifted below 256.
	always_comb begin
		above           = sample > cfg.cal_center;
		mag_raw         = above ? SAMPLE_W'(sample - cfg.cal_center)
		                        : SAMPLE_W'(cfg.cal_center - sample);
		front.neg       = sample < cfg.cal_center;
		front.at_low    = sample <= cfg.cal_low;
		front.at_high   = sample >= cfg.cal_high;
		front.span      = above ? SAMPLE_W'(cfg.cal_high - cfg.cal_center)
		                        : SAMPLE_W'(cfg.cal_center - cfg.cal_low);
		front.span_zero = front.span == '0;
		front.quo       = '0;
		if (mag_raw[9]) begin
			front.shifts = 2'd2;
			front.rem    = SAMPLE_W'(mag_raw >> 2);
		end else if (mag_raw[8]) begin
			front.shifts = 2'd1;
			front.rem    = SAMPLE_W'(mag_raw >> 1);
		end else begin
			front.shifts = 2'd0;
			front.rem    = mag_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvalid_s[0] <= 1'b0;
		end else if (en) begin
			dvalid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dstage_s[0] <= front;
		end
	end

	// One quotient bit per stage; the remainder stays below the span.
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		logic [SAMPLE_W:0] rem2;
		logic              take;
		div_t              nxt;

		always_comb begin
			rem2     = {dstage_s[k-1].rem, 1'b0};
			take     = rem2 >= {1'b0, dstage_s[k-1].span};
			nxt      = dstage_s[k-1];
			nxt.rem  = take ? SAMPLE_W'(rem2 - {1'b0, dstage_s[k-1].span})
			                : SAMPLE_W'(rem2);
			nxt.quo  = {dstage_s[k-1].quo[6:0], take};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvalid_s[k] <= 1'b0;
			end else if (en) begin
				dvalid_s[k] <= dvalid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dstage_s[k] <= nxt;
			end
		end
	end

	// Undo the pre-shift, saturate, and apply the end tests.
	assign q_shift = SAMPLE_W'({2'b00, dstage_s[DIV_STEPS].quo} << dstage_s[DIV_STEPS].shifts);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dvalid_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dstage_s[DIV_STEPS].at_low) begin
				out_neg <= 1'b1;
				out_mag <= MAG_FULL;
			end else if (dstage_s[DIV_STEPS].at_high) begin
				out_neg <= 1'b0;
				out_mag <= MAG_FULL;
			end else begin
				out_neg <= dstage_s[DIV_STEPS].neg;
				if (dstage_s[DIV_STEPS].span_zero || q_shift > {1'b0, MAG_FULL}) begin
					out_mag <= MAG_FULL;
				end else begin
					out_mag <= q_shift[8:0];
				end
			end
		end
	end

endmodule

// ----- src/rcm_shape.sv -----
// Expo interpolation in the curve tables followed by dual-rate scaling, both bypassed when mode bit 1 is set.
// Depends on rcm_pkg.
module rcm_shape (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic          in_neg,
	input  logic [8:0]    in_mag,
	input  rcm_pkg::cfg_t cfg,
	output logic          out_valid,
	output logic          out_neg,
	output logic [9:0]    out_mag
);
	import rcm_pkg::*;

	logic [7:0]  e_abs;
	logic [6:0]  e_sat;
	logic        cubic;
	logic        bypass;
	logic [4:0]  idx;
	logic [3:0]  frac;
	logic [14:0] ev_sum;
	logic [16:0] mix_sum;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [8:0]  mag_s1, mag_s2, mag_s3;
	logic        keep_s1, keep_s2, keep_s3;
	logic [6:0]  e_s1;
	logic [13:0] lo_s1;
	logic [12:0] hi_s1;
	logic [15:0] pa_s2, pb_s2;
	logic [34:0] prod_s3;
	logic [8:0]  mage_s4, mage_s5;
	logic [16:0] rp_s4;
	logic [34:0] rq_s5;

	function automatic logic [15:0] in_mag_mul(input logic [8:0] a, input logic [6:0] b);
		return 16'(a * b);
	endfunction

	// Expo weight, saturated at full percent, and table choice.
	always_comb begin
		e_abs  = cfg.expo_amount[7] ? 8'(-cfg.expo_amount) : 8'(cfg.expo_amount);
		e_sat  = (e_abs > {1'b0, PCT_FULL}) ? PCT_FULL : e_abs[6:0];
		cubic  = !cfg.expo_amount[7];
		bypass = cfg.mode_bits[1];
		idx    = in_mag[8:4];
		frac   = in_mag[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			out_valid <= v_s5;
		end
	end

	assign ev_sum  = 15'(lo_s1) + 15'(hi_s1);
	assign mix_sum = 17'(pa_s2) + 17'(pb_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			// Weighted neighbours in the curve.
			lo_s1   <= 14'(curve_at(cubic, idx) * (5'd16 - 5'(frac)));
			hi_s1   <= 13'(curve_at(cubic, 5'(idx + 5'd1)) * frac);
			mag_s1  <= in_mag;
			neg_s1  <= in_neg;
			e_s1    <= e_sat;
			keep_s1 <= bypass || (cfg.expo_amount == '0);

			// Blend of linear and curve values.
			pa_s2   <= 16'(in_mag_mul(mag_s1, 7'(PCT_FULL - e_s1)));
			pb_s2   <= 16'(in_mag_mul(ev_sum[12:4], e_s1));
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			keep_s2 <= keep_s1;

			// Divide the blend by 100.
			prod_s3 <= 35'(mix_sum * DIV100_MUL);
			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
			keep_s3 <= keep_s2;

			// Dual-rate product.
			mage_s4 <= keep_s3 ? mag_s3 : prod_s3[DIV100_SH +: 9];
			rp_s4   <= 17'((keep_s3 ? mag_s3 : prod_s3[DIV100_SH +: 9]) * cfg.rate_percent);
			neg_s4  <= neg_s3;

			// Divide the rate product by 100.
			rq_s5   <= 35'(rp_s4 * DIV100_MUL);
			mage_s5 <= mage_s4;
			neg_s5  <= neg_s4;

			out_mag <= bypass ? 10'(mage_s5) : rq_s5[DIV100_SH +: 10];
			out_neg <= neg_s5;
		end
	end

endmodule

// ----- src/rcm_endpt.sv -----
// Subtrim, endpoint scaling with clamp, reverse and the mapping to the 0..255 channel range.
// Depends on rcm_pkg.
module rcm_endpt (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic          in_neg,
	input  logic [9:0]    in_mag,
	input  rcm_pkg::cfg_t cfg,
	output logic          out_valid,
	output logic [7:0]    out_value
);
	import rcm_pkg::*;

	logic signed [10:0] v_trim;
	logic [9:0]         v_abs;
	logic [7:0]         ep;
	logic [7:0]         m_clamp;
	logic               flip;
	logic [8:0]         mapped;

	logic        v_s1, v_s2;
	logic        neg_s1, neg_s2;
	logic [17:0] p_s1;
	logic [35:0] q_s2;

	// Signed value plus trim, and endpoint chosen by its sign.
	always_comb begin
		v_trim = (in_neg ? -$signed({1'b0, in_mag}) : $signed({1'b0, in_mag}))
		         + 11'(cfg.sub_trim);
		ep     = (v_trim > 0) ? cfg.end_points[15:8] : cfg.end_points[7:0];
		v_abs  = v_trim[10] ? 10'(-v_trim) : 10'(v_trim);
	end

	// Clamp, reverse and map to the channel range.
	always_comb begin
		m_clamp = (q_s2[DIV140_SH +: 11] > 11'(OUT_MAX)) ? OUT_MAX : q_s2[DIV140_SH +: 8];
		flip    = neg_s2 ^ cfg.mode_bits[0];
		mapped  = flip ? 9'({1'b0, OUT_MAX} - {1'b0, m_clamp})
		               : 9'({1'b0, OUT_MAX} + {1'b0, m_clamp});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1      <= 18'(v_abs * ep);
			neg_s1    <= v_trim[10];
			q_s2      <= 36'(p_s1 * DIV140_MUL);
			neg_s2    <= neg_s1;
			out_value <= mapped[8:1];
		end
	end

endmodule

// ----- verif/tb_rc_stick_channel_mixer.sv -----
// Self-checking testbench for the stick channel mixer: directed table, then random samples.
// Depends on rcm_pkg and rc_stick_channel_mixer; computes expected channel values itself.
`timescale 1ns / 1ps

module tb_rc_stick_channel_mixer;
	import rcm_pkg::*;

	localparam int LATENCY  = 19;
	localparam int WD_LIMIT = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [9:0]  stick_sample = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  channel_value;
	logic        wr_en = 1'b0;
	logic [2:0]  wr_index = '0;
	logic [15:0] wr_data = '0;

	// Local copy of the register file.
	int unsigned m_low, m_mid, m_high, m_rate, m_ep, m_mode;
	int          m_expo, m_trim;

	logic [7:0] expected_values[$];
	int         errors = 0;
	int         idle_cycles = 0;
	int         src_gap_pct = 6;
	int         snk_gap_pct = 69;
	bit         timed_out = 1'b0;

	typedef struct {
		logic [9:0] sample;
		int         golden; // -1 when the predictor alone decides
	} stim_row_t;

	rc_stick_channel_mixer i_dut (.*);

	always #6 clk = ~clk;

	function automatic int unsigned curve_point(bit cubic, int unsigned idx);
		int unsigned cub[15] = '{0, 1, 2, 4, 8, 14, 21, 32, 46, 63, 83, 108, 137, 171, 210};
		int unsigned rt[15] = '{101, 128, 147, 161, 174, 185, 194, 203, 211, 219, 226, 232,
			239, 245, 251};
		if (idx == 0) return 0;
		if (idx > 15) return 256;
		return cubic ? cub[idx-1] : rt[idx-1];
	endfunction

	// Work out the channel value for one stick sample under the current settings.
	function automatic logic [7:0] mix_channel(int unsigned raw);
		int unsigned mag, span, e, idx, rem, ev, ep;
		int          shifts, v;
		bit          neg;
		shifts = 0;
		if (raw <= m_low) v = -256;
		else if (raw >= m_high) v = 256;
		else begin
			if (raw > m_mid) begin
				mag = raw - m_mid; span = m_high - m_mid;
			end else begin
				mag = m_mid - raw; span = m_mid - m_low;
			end
			if (span == 0) mag = 256;
			else begin
				while (mag >= 256) begin mag >>= 1; shifts++; end
				mag = (mag << 8) / span;
				mag = mag << shifts;
				if (mag > 256) mag = 256;
			end
			v = (raw < m_mid) ? -int'(mag) : int'(mag);
		end
		if (!m_mode[1]) begin
			// Expo blend, then dual rate.
			if (m_expo != 0) begin
				e = (m_expo < 0) ? -m_expo : m_expo;
				if (e > 100) e = 100;
				neg = v < 0;
				mag = neg ? -v : v;
				idx = mag >> 4;
				rem = mag & 4'hF;
				ev = (curve_point(m_expo > 0, idx) * (16 - rem)
					+ curve_point(m_expo > 0, idx + 1) * rem) >> 4;
				mag = (mag * (100 - e) + ev * e) / 100;
				v = neg ? -int'(mag) : int'(mag);
			end
			neg = v < 0;
			mag = neg ? -v : v;
			mag = (mag * m_rate) / 100;
			v = neg ? -int'(mag) : int'(mag);
		end
		// Subtrim, endpoint and reverse.
		v += m_trim;
		ep = (v > 0) ? ((m_ep >> 8) & 8'hFF) : (m_ep & 8'hFF);
		neg = v < 0;
		mag = neg ? -v : v;
		mag = (mag * ep) / 140;
		if (mag > 255) mag = 255;
		v = neg ? -int'(mag) : int'(mag);
		if (m_mode[0]) v = -v;
		return 8'((v + 255) / 2);
	endfunction

	// One register write; the enable stays high across a run of writes.
	task automatic write_reg(reg_idx_t idx, int unsigned value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= 16'(value);
		@(posedge clk);
		case (idx)
			REG_CAL_LOW:     m_low = value & 10'h3FF;
			REG_CAL_CENTER:  m_mid = value & 10'h3FF;
			REG_CAL_HIGH:    m_high = value & 10'h3FF;
			REG_EXPO_AMOUNT: m_expo = int'(signed'(8'(value)));
			REG_RATE:        m_rate = value & 8'hFF;
			REG_SUB_TRIM:    m_trim = int'(signed'(8'(value)));
			REG_END_POINTS:  m_ep = value & 16'hFFFF;
			REG_MODE_BITS:   m_mode = value & 2'h3;
			default: ;
		endcase
	endtask

	task automatic load_setting(int unsigned lo, int unsigned ce, int unsigned hi, int ex,
		int unsigned rt, int tr, int unsigned ep, int unsigned md);
		write_reg(REG_CAL_LOW, lo);
		write_reg(REG_CAL_CENTER, ce);
		write_reg(REG_CAL_HIGH, hi);
		write_reg(REG_EXPO_AMOUNT, 8'(ex));
		write_reg(REG_RATE, rt);
		write_reg(REG_SUB_TRIM, 8'(tr));
		write_reg(REG_END_POINTS, ep);
		write_reg(REG_MODE_BITS, md);
		wr_en <= 1'b0;
	endtask

	// Present one beat, holding it until accepted; random gaps before it.
	task automatic send_sample(logic [9:0] s);
		while ($urandom_range(99) < src_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		stick_sample <= s;
		expected_values.push_back(mix_channel(s));
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_values.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Random sample, weighted towards the calibration points.
	function automatic logic [9:0] pick_sample();
		case ($urandom_range(5))
			0: return 10'(m_low + $urandom_range(2) - 1);
			1: return 10'(m_mid + $urandom_range(2) - 1);
			2: return 10'(m_high + $urandom_range(2) - 1);
			default: return 10'($urandom);
		endcase
	endfunction

	// Receiver: random stall, compare each beat with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_values.size() == 0) begin
					$error("channel_value: none expected, actual %0d", channel_value);
					errors++;
				end else if (channel_value !== expected_values[0]) begin
					$error("channel_value: expected %0d, actual %0d",
						expected_values[0], channel_value);
					errors++;
					void'(expected_values.pop_front());
				end else begin
					void'(expected_values.pop_front());
				end
			end
			out_stall <= ($urandom_range(99) < snk_gap_pct);
		end
	end

	// Watchdog on cycles without any accepted beat or register write.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WD_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("FAIL rc_stick_channel_mixer");
			$finish;
		end
	end

	initial begin
		stim_row_t table_rows[$];
		int        phase;
		m_low = 0; m_mid = 512; m_high = 1023; m_expo = 0;
		m_rate = 100; m_trim = 0; m_ep = 35980; m_mode = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, ends give full scale, centre gives mid value.
		table_rows = '{
			'{10'd0, 0}, '{10'd1023, 255}, '{10'd512, 127}, '{10'd511, -1},
			'{10'd513, -1}, '{10'd256, -1}, '{10'd768, -1}, '{10'h155, -1},
			'{10'h2AA, -1}};
		foreach (table_rows[i]) begin
			if (table_rows[i].golden >= 0 && mix_channel(table_rows[i].sample)
					!= 8'(table_rows[i].golden)) begin
				$error("channel_value: expected %0d, actual %0d", table_rows[i].golden,
					mix_channel(table_rows[i].sample));
				errors++;
			end
			send_sample(table_rows[i].sample);
		end
		drain();
		// Expo extremes, out-of-range expo, inverted and zero-span calibration, reverse.
		load_setting(100, 500, 900, 100, 255, 127, 16'hFF00, 1);
		foreach (table_rows[i]) send_sample(table_rows[i].sample);
		send_sample(10'd100); send_sample(10'd900); send_sample(10'd501);
		drain();
		load_setting(600, 600, 400, -128, 0, -128, 16'h00FF, 2);
		send_sample(10'd500); send_sample(10'd600); send_sample(10'd0);
		send_sample(10'd1023); send_sample(10'd399);
		drain();
		load_setting(0, 1023, 1023, -100, 150, -5, 16'h8CFF, 3);
		send_sample(10'd1); send_sample(10'd1022); send_sample(10'd700);
		drain();

		// Random phases with fresh settings between them.
		for (phase = 0; phase < 12; phase++) begin
			if (phase == 4) begin src_gap_pct = 69; snk_gap_pct = 6; end
			if (phase == 8) begin src_gap_pct = 0; snk_gap_pct = 0; end
			m_low = $urandom_range(400);
			m_high = $urandom_range(1023, 600);
			load_setting(m_low, $urandom_range(m_high, m_low), m_high,
				$urandom_range(255) - 128, $urandom_range(255), $urandom_range(255) - 128,
				$urandom_range(16'hFFFF), $urandom_range(3));
			repeat (120) send_sample(pick_sample());
			drain();
		end

		if (errors == 0 && expected_values.size() == 0) begin
			$display("PASS rc_stick_channel_mixer");
		end else begin
			$display("FAIL rc_stick_channel_mixer");
		end
		$finish;
	end

endmodule
